[hw/rtl/htfd_pkg.sv]
// Shared types and constants for the humidity and temperature frame decoder.
package htfd_pkg;

  // Frame layout and CRC-8 parameters.
  localparam logic [7:0] CRC_POLY   = 8'h31;
  localparam logic [7:0] CRC_INIT   = 8'hFF;
  localparam logic [2:0] FRAME_LAST = 3'd6;
  localparam int         FRAME_CAP  = 6;
  localparam int         POS_W      = 3;

  // Raw sample width and scaling. (raw*2000>>3)*5 equals raw*1250 and
  // (raw*1000>>3)*5 equals raw*625, since both divisions by eight are exact.
  localparam int          RAW_W       = 20;
  localparam int          TSCALE_W    = 11;
  localparam int          HSCALE_W    = 10;
  localparam int          TPROD_W     = RAW_W + TSCALE_W;
  localparam int          HPROD_W     = RAW_W + HSCALE_W;
  localparam int          FRAC_W      = 16;
  localparam int          TEMP_W      = 15;
  localparam int          HUM_W       = 14;
  localparam logic [TSCALE_W-1:0] TEMP_SCALE  = 11'd1250;
  localparam logic [HSCALE_W-1:0] HUM_SCALE   = 10'd625;
  localparam logic [TEMP_W-1:0]   TEMP_OFFSET = 15'd5000;

  // Queue between the framing front end and the scaling back end.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;
  localparam int Q_CW    = 2;

  // One completed frame, as handed from the front end to the back end.
  typedef struct packed {
    logic             busy;
    logic             calibrated;
    logic             crc_error;
    logic [RAW_W-1:0] t_raw;
    logic [RAW_W-1:0] h_raw;
    logic [7:0]       rx_crc;
  } htfd_entry_t;

  // Front-end status seen by the top level.
  typedef struct packed {
    logic [POS_W-1:0] pos;
  } htfd_front_stat_t;

endpackage

[hw/rtl/humidity_temp_frame_decoder.sv]
// Top level of the humidity and temperature measurement frame decoder.
//
// The input channel takes the sensor reply one byte per transfer (in_rx_byte),
// with in_frame_start marking the status byte. Without a start flag the block
// frames freely: after reset or after a result the next byte is byte 0.
// Bytes 0 to 5 are captured and folded into a CRC-8 (poly 0x31, init 0xFF).
// Byte 6 is the received CRC and completes the frame: one result transfer
// follows with status flags, CRC check, temperature and humidity.
// Throughput is one byte per cycle while the queue is not full. A result
// passes through the two-entry queue and the multiply stage into the output
// register, which drives out_valid. When the receiver stalls, results collect
// in the multiply stage and the queue; in_ready drops while the queue is full,
// for bytes 0 to 5 as well as for the CRC byte. Reset clears the framing
// position, the CRC, the queue and all valid bits; no result is pending after
// reset.
module humidity_temp_frame_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_rx_byte,
  input  logic                               in_frame_start,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_busy_flag,
  output logic                               out_calibrated_flag,
  output logic                               out_crc_error,
  output logic signed [htfd_pkg::TEMP_W-1:0] out_temperature_centi,
  output logic [htfd_pkg::HUM_W-1:0]         out_humidity_centi,
  output logic [7:0]                         out_received_crc
);
  import htfd_pkg::*;

  htfd_entry_t      push_data;
  htfd_entry_t      pop_data;
  htfd_front_stat_t front_stat;
  logic             push_valid;
  logic             q_full;
  logic             pop_valid;
  logic             pop_ready;

  // Framing, CRC and capture.
  htfd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .in_frame_start (in_frame_start),
    .push_valid     (push_valid),
    .push_data      (push_data),
    .q_full         (q_full),
    .stat           (front_stat)
  );

  // Completed frames waiting for scaling.
  htfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Scaling and result register.
  htfd_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .pop_valid             (pop_valid),
    .pop_ready             (pop_ready),
    .pop_data              (pop_data),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_busy_flag         (out_busy_flag),
    .out_calibrated_flag   (out_calibrated_flag),
    .out_crc_error         (out_crc_error),
    .out_temperature_centi (out_temperature_centi),
    .out_humidity_centi    (out_humidity_centi),
    .out_received_crc      (out_received_crc)
  );

  // A transfer of the CRC byte always leaves a frame in the queue.
  a_last_byte_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_frame_start && front_stat.pos == FRAME_LAST)
      |=> pop_valid)
    else $error("completed frame did not reach the queue");

  // No result is pending right after reset.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Scaled humidity stays within its range.
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_humidity_centi <= 14'd10000))
    else $error("humidity out of range");

  // Scaled temperature stays within its range.
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_temperature_centi >= -15'sd5000) &&
                   (out_temperature_centi <= 15'sd15000)))
    else $error("temperature out of range");

endmodule

[hw/rtl/htfd_front.sv]
// Front end: frame position tracking, running CRC-8 and byte capture.
module htfd_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_rx_byte,
  input  logic                       in_frame_start,
  output logic                       push_valid,
  output htfd_pkg::htfd_entry_t      push_data,
  input  logic                       q_full,
  output htfd_pkg::htfd_front_stat_t stat
);
  import htfd_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic [7:0]       cap_r [FRAME_CAP];
  logic [POS_W-1:0] pos_eff;
  logic [7:0]       crc_base;
  logic             accept;
  logic             is_last;

  // Bitwise MSB-first CRC-8 over one byte.
  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // A byte is taken whenever the queue can hold a possible result.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Effective position: a start flag or an out-of-range count restarts framing.
  always_comb begin
    if (in_frame_start || (pos_r > FRAME_LAST)) begin
      pos_eff = '0;
    end else begin
      pos_eff = pos_r;
    end
    crc_base = (pos_eff == '0) ? CRC_INIT : crc_r;
    is_last  = (pos_eff == FRAME_LAST);
  end

  // Next position and CRC.
  always_comb begin
    pos_nxt = pos_r;
    crc_nxt = crc_r;
    if (accept) begin
      if (is_last) begin
        pos_nxt = '0;
        crc_nxt = CRC_INIT;
      end else begin
        pos_nxt = pos_eff + 1'b1;
        crc_nxt = crc_fold(crc_base, in_rx_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      crc_r <= CRC_INIT;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
    end
  end

  // Capture bytes 0 to 5 of the frame.
  always_ff @(posedge clk) begin
    if (accept && !is_last) begin
      cap_r[pos_eff] <= in_rx_byte;
    end
  end

  // The CRC byte completes a frame and goes to the queue.
  assign push_valid           = accept && is_last;
  assign push_data.busy       = cap_r[0][7];
  assign push_data.calibrated = cap_r[0][3];
  assign push_data.crc_error  = (crc_base != in_rx_byte);
  assign push_data.t_raw      = {cap_r[3][3:0], cap_r[4], cap_r[5]};
  assign push_data.h_raw      = {cap_r[1], cap_r[2], cap_r[3][7:4]};
  assign push_data.rx_crc     = in_rx_byte;
  assign stat.pos             = pos_r;

endmodule

[hw/rtl/htfd_queue.sv]
// Two-entry queue that decouples frame capture from result scaling.
module htfd_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  input  htfd_pkg::htfd_entry_t push_data,
  output logic                  full,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output htfd_pkg::htfd_entry_t pop_data
);
  import htfd_pkg::*;

  htfd_entry_t     mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;
  logic            push;
  logic            pop;

  assign full      = (count_r == Q_CW'(Q_DEPTH));
  assign pop_valid = (count_r != '0);
  assign push      = push_valid && !full;
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hw/rtl/htfd_back.sv]
// Back end: scales raw samples to centi-units and holds the result register.
module htfd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  htfd_pkg::htfd_entry_t       pop_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_busy_flag,
  output logic                        out_calibrated_flag,
  output logic                        out_crc_error,
  output logic signed [htfd_pkg::TEMP_W-1:0] out_temperature_centi,
  output logic [htfd_pkg::HUM_W-1:0]  out_humidity_centi,
  output logic [7:0]                  out_received_crc
);
  import htfd_pkg::*;

  logic               mul_valid_r;
  logic [TPROD_W-1:0] t_prod_r;
  logic [HPROD_W-1:0] h_prod_r;
  logic               busy_r, cal_r, err_r;
  logic [7:0]         crc_r;
  logic               out_valid_r;
  logic [TEMP_W-1:0]  temp_r;
  logic [HUM_W-1:0]   hum_r;
  logic               busy_o_r, cal_o_r, err_o_r;
  logic [7:0]         crc_o_r;
  logic               out_adv;
  logic               mul_adv;
  logic [TEMP_W-1:0]  temp_nxt;

  // Stage advance: the output register frees when empty or taken.
  assign out_adv   = !out_valid_r || out_ready;
  assign mul_adv   = !mul_valid_r || out_adv;
  assign pop_ready = mul_adv;

  // Temperature offset; the 15-bit wraparound gives the two's complement.
  assign temp_nxt = TEMP_W'(t_prod_r[TPROD_W-1:FRAC_W]) - TEMP_OFFSET;

  // Valid bits of both stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (mul_adv) begin
        mul_valid_r <= pop_valid;
      end
      if (out_adv) begin
        out_valid_r <= mul_valid_r;
      end
    end
  end

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (mul_adv && pop_valid) begin
      t_prod_r <= TPROD_W'(pop_data.t_raw) * TPROD_W'(TEMP_SCALE);
      h_prod_r <= HPROD_W'(pop_data.h_raw) * HPROD_W'(HUM_SCALE);
      busy_r   <= pop_data.busy;
      cal_r    <= pop_data.calibrated;
      err_r    <= pop_data.crc_error;
      crc_r    <= pop_data.rx_crc;
    end
  end

  // Output register: shift down, remove offset.
  always_ff @(posedge clk) begin
    if (out_adv && mul_valid_r) begin
      temp_r   <= temp_nxt;
      hum_r    <= h_prod_r[FRAC_W +: HUM_W];
      busy_o_r <= busy_r;
      cal_o_r  <= cal_r;
      err_o_r  <= err_r;
      crc_o_r  <= crc_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_busy_flag         = busy_o_r;
  assign out_calibrated_flag   = cal_o_r;
  assign out_crc_error         = err_o_r;
  assign out_temperature_centi = $signed(temp_r);
  assign out_humidity_centi    = hum_r;
  assign out_received_crc      = crc_o_r;

endmodule

[sim/tb.sv]
// Self-checking testbench for the humidity and temperature frame decoder.
module tb;
  import htfd_pkg::*;

  // Scaling constants of the sensor conversion formulas.
  localparam longint unsigned TEMP_GAIN  = 2000;
  localparam longint unsigned HUM_GAIN   = 1000;
  localparam longint unsigned POST_GAIN  = 5;
  localparam longint          TEMP_SHIFT = 5000;
  localparam logic [7:0]      NIBBLE     = 8'h0F;
  localparam int              ITEM_GOAL  = 650;
  localparam int              CYCLE_LIMIT = 200000;
  localparam int              DRAIN_CYCLES = 16;

  // One received byte and its start marker.
  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } rx_item_t;

  // One decoded measurement.
  typedef struct packed {
    logic              busy;
    logic              calibrated;
    logic              crc_error;
    logic [TEMP_W-1:0] temp;
    logic [HUM_W-1:0]  hum;
    logic [7:0]        rx_crc;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic in_frame_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_busy_flag;
  logic out_calibrated_flag;
  logic out_crc_error;
  logic signed [TEMP_W-1:0] out_temperature_centi;
  logic [HUM_W-1:0] out_humidity_centi;
  logic [7:0] out_received_crc;

  rx_item_t pending_bytes[$];
  reading_t expected_readings[$];
  rx_item_t next_item;

  // Predicted framing state.
  logic [2:0] frame_pos = '0;
  logic [7:0] frame_crc = CRC_INIT;
  logic [7:0] frame_buf[FRAME_CAP];

  // Framing position as the stimulus generator sees it.
  logic [2:0] gen_pos = '0;

  int mismatches = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int item_count = 0;
  logic [15:0] stall_pattern = 16'hFFFF;
  logic [3:0]  stall_idx = '0;

  humidity_temp_frame_decoder dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_rx_byte            (in_rx_byte),
    .in_frame_start        (in_frame_start),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_busy_flag         (out_busy_flag),
    .out_calibrated_flag   (out_calibrated_flag),
    .out_crc_error         (out_crc_error),
    .out_temperature_centi (out_temperature_centi),
    .out_humidity_centi    (out_humidity_centi),
    .out_received_crc      (out_received_crc)
  );

  // Clock generation.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // One MSB-first CRC-8 step over a byte.
  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  // Follows the framing of the block for one accepted byte and queues the
  // decoded reading when the byte closes a frame.
  task automatic decode_byte(input logic [7:0] b, input logic start);
    reading_t r;
    longint unsigned t20;
    longint unsigned h20;
    longint unsigned tv;
    longint unsigned hv;
    longint tc;
    if (start) begin
      frame_pos = '0;
    end
    if (frame_pos > FRAME_LAST) begin
      frame_pos = '0;
    end
    if (frame_pos == 0) begin
      frame_crc = CRC_INIT;
    end
    if (frame_pos < FRAME_LAST) begin
      frame_buf[frame_pos] = b;
      frame_crc = crc8_fold(frame_crc, b);
      frame_pos = frame_pos + 3'd1;
    end else begin
      t20 = {frame_buf[3] & NIBBLE, frame_buf[4], frame_buf[5]};
      h20 = {frame_buf[1], frame_buf[2], frame_buf[3]};
      h20 = h20 >> 4;
      tv = (((t20 * TEMP_GAIN) >> 3) * POST_GAIN) >> 16;
      hv = (((h20 * HUM_GAIN) >> 3) * POST_GAIN) >> 16;
      tc = longint'(tv) - TEMP_SHIFT;
      r.busy = frame_buf[0][7];
      r.calibrated = frame_buf[0][3];
      r.crc_error = (frame_crc != b);
      r.temp = tc[TEMP_W-1:0];
      r.hum = hv[HUM_W-1:0];
      r.rx_crc = b;
      expected_readings.push_back(r);
      frame_pos = '0;
      frame_crc = CRC_INIT;
    end
  endtask

  // Queues one byte for the driver and tracks where it lands in a frame.
  task automatic queue_byte(input logic [7:0] b, input logic start);
    rx_item_t it;
    it.data = b;
    it.start = start;
    pending_bytes.push_back(it);
    item_count++;
    if (start || gen_pos >= FRAME_LAST) begin
      gen_pos = start ? 3'd1 : 3'd0;
    end else begin
      gen_pos = gen_pos + 3'd1;
    end
  endtask

  // Queues a complete frame; bytes are packed with the status byte on top.
  task automatic queue_frame(input logic [47:0] body, input logic start, input bit good_crc);
    logic [7:0] crc;
    logic [7:0] b;
    crc = CRC_INIT;
    for (int i = 0; i < FRAME_CAP; i++) begin
      b = body[47 - 8*i -: 8];
      crc = crc8_fold(crc, b);
      queue_byte(b, (i == 0) ? start : 1'b0);
    end
    if (!good_crc) begin
      crc = crc ^ 8'($urandom_range(1, 255));
    end
    queue_byte(crc, 1'b0);
  endtask

  // Random data byte, leaning toward the ends of the range.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch: %s", msg);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      report_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
    end
  endtask

  // Reset, stimulus build-up and end of run.
  initial begin
    logic [47:0] body;
    logic start;
    int len;
    // Zero frame: lowest temperature and humidity, calibrated status.
    queue_frame({8'h1C, 40'h0}, 1'b1, 1'b1);
    // Partial frame cut off by a new start flag.
    queue_byte(8'h98, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    // All-ones frame: top of both ranges, busy, with a bad CRC byte.
    queue_frame({8'h88, 40'hFF_FFFF_FFFF}, 1'b1, 1'b0);
    // Free-running frame with no start flag, busy only.
    queue_frame({8'h80, 40'h66_5A35_8CA3}, 1'b0, 1'b1);

    // Random part: mostly well-formed frames, some noise and broken frames.
    while (item_count < ITEM_GOAL) begin
      if ($urandom_range(0, 6) != 0) begin
        for (int i = 0; i < FRAME_CAP; i++) begin
          body[47 - 8*i -: 8] = pick_byte();
        end
        start = (gen_pos != 0) || ($urandom_range(0, 1) == 1);
        queue_frame(body, start, $urandom_range(0, 6) != 0);
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          queue_byte(8'($urandom), $urandom_range(0, 3) == 0);
        end
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (expected_readings.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Byte driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(in_rx_byte, in_frame_start);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          next_item = pending_bytes.pop_front();
          in_rx_byte <= next_item.data;
          in_frame_start <= next_item.start;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: stalls follow a 16-bit pattern that is chosen anew after each pass through it.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_idx <= '0;
    end else begin
      out_ready <= stall_pattern[stall_idx];
      stall_idx <= stall_idx + 4'd1;
      if (stall_idx == 4'd15) begin
        case ($urandom_range(0, 3))
          0: stall_pattern <= 16'hFFFF;
          1: stall_pattern <= 16'h0000;
          2: stall_pattern <= 16'($urandom);
          default: stall_pattern <= 16'($urandom | $urandom);
        endcase
      end
    end
  end

  // Result monitor: each transfer is compared with the oldest prediction.
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch($sformatf("unexpected result, temperature %0d humidity %0d",
                                  out_temperature_centi, out_humidity_centi));
      end else begin
        want = expected_readings.pop_front();
        check_field("busy_flag", int'(want.busy), int'(out_busy_flag));
        check_field("calibrated_flag", int'(want.calibrated), int'(out_calibrated_flag));
        check_field("crc_error", int'(want.crc_error), int'(out_crc_error));
        check_field("temperature_centi", int'($signed(want.temp)),
                    int'(out_temperature_centi));
        check_field("humidity_centi", int'(want.hum), int'(out_humidity_centi));
        check_field("received_crc", int'(want.rx_crc), int'(out_received_crc));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

[filelist.f]
hw/rtl/htfd_pkg.sv
hw/rtl/htfd_front.sv
hw/rtl/htfd_queue.sv
hw/rtl/htfd_back.sv
hw/rtl/humidity_temp_frame_decoder.sv
sim/tb.sv
